FILE: design/led_matrix_frame_buffer_driver_core_assert.svh
// Assertion macros for the LED matrix frame buffer driver core.
`ifndef LED_MATRIX_FRAME_BUFFER_DRIVER_CORE_ASSERT_SVH
`define LED_MATRIX_FRAME_BUFFER_DRIVER_CORE_ASSERT_SVH

// Holds at every clock edge outside reset.
`define LMFB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LMFB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/lmfb_pkg.sv
// Shared types, codes and helpers for the LED matrix frame buffer driver.
package lmfb_pkg;

	localparam int MAX_DEVICES = 4;
	localparam int ROWS        = 8;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [1:0] FUNC_PIXEL   = 2'd0;
	localparam logic [1:0] FUNC_ROW     = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;
	localparam logic [1:0] FUNC_REFRESH = 2'd3;

	localparam logic [0:0] REG_DEVICES   = 1'b0;
	localparam logic [2:0] DEVICES_RESET = 3'd4;
	localparam logic [7:0] TOP_BIT       = 8'h80;

	typedef struct packed {
		logic [1:0] func;
		logic [4:0] column;
		logic [2:0] bit_row;
		logic       pixel_on;
		logic [7:0] row_value;
		logic       invert;
	} cmd_t;

	typedef struct packed {
		logic [63:0] frame_bits;
		logic        last_frame;
	} frame_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} back_status_t;

	// Chip count as used: 0 acts as 1, anything above the chain size saturates.
	function automatic logic [2:0] chips_eff(input logic [2:0] dev);
		logic [2:0] n;
		n = dev;
		if (dev == 3'd0)
			n = 3'd1;
		else if (dev > 3'(MAX_DEVICES))
			n = 3'(MAX_DEVICES);
		return n;
	endfunction

	// One chip word: digit register k+1 in the high byte, data in the low byte.
	function automatic logic [15:0] chip_word(input logic [2:0] k, input logic [7:0] data);
		logic [7:0] reg_num;
		reg_num = 8'(k) + 8'd1;
		return {reg_num, data};
	endfunction

endpackage

FILE: design/lmfb_front.sv
// Front end: takes command words, drops out-of-range columns, queues the rest.
module lmfb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  lmfb_pkg::cmd_t    cmd,
	input  logic [2:0]        n_eff,
	input  logic              pop,
	output logic              q_avail,
	output lmfb_pkg::cmd_t    q_head
);

	lmfb_pkg::cmd_t                  q_mem_q [lmfb_pkg::QDEPTH];
	logic [lmfb_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [lmfb_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [lmfb_pkg::QCNT_W-1:0]     count_q;
	logic                            keep;
	logic                            push;

	always_comb begin
		case (cmd.func)
			lmfb_pkg::FUNC_PIXEL, lmfb_pkg::FUNC_ROW: begin
				keep = {1'b0, cmd.column[4:3]} < n_eff;
			end
			default: begin
				keep = 1'b1;
			end
		endcase
	end

	assign cmd_ready = count_q != lmfb_pkg::QCNT_W'(lmfb_pkg::QDEPTH);
	// dropped words are accepted but never queued
	assign push      = cmd_valid && cmd_ready && keep;
	assign q_avail   = count_q != '0;
	assign q_head    = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + lmfb_pkg::QCNT_W'(push) - lmfb_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= cmd;
	end

endmodule

FILE: design/lmfb_back.sv
// Back end: frame buffer, command sequencer and output word register.
module lmfb_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_avail,
	input  lmfb_pkg::cmd_t           q_head,
	input  logic [2:0]               n_eff,
	output lmfb_pkg::back_status_t   status,
	output logic                     frame_valid,
	input  logic                     frame_ready,
	output lmfb_pkg::frame_t         frame
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	state_t             state_q;
	lmfb_pkg::cmd_t     cmd_q;
	logic [4:0]         cnt_q;
	logic [7:0]         fb_q [lmfb_pkg::MAX_DEVICES][lmfb_pkg::ROWS];
	logic               frame_valid_q;
	lmfb_pkg::frame_t   frame_q;

	logic               advance;
	logic               emit;
	logic               pop;
	logic [1:0]         chip;
	logic [2:0]         row;
	logic [7:0]         cur;
	logic [7:0]         mask;
	logic [7:0]         new_val;
	logic [1:0]         last_chip;
	lmfb_pkg::frame_t   frame_d;

	assign advance = !frame_valid_q || frame_ready;
	assign emit    = (state_q == ST_BUSY) && advance;
	assign pop     = (state_q == ST_IDLE) && q_avail;

	assign chip      = cmd_q.column[4:3];
	assign row       = cmd_q.column[2:0];
	assign cur       = fb_q[chip][row];
	assign mask      = lmfb_pkg::TOP_BIT >> cmd_q.bit_row;
	assign last_chip = 2'(n_eff - 3'd1);

	always_comb begin
		if (cmd_q.func == lmfb_pkg::FUNC_ROW)
			new_val = cmd_q.row_value;
		else if (cmd_q.pixel_on)
			new_val = cur | mask;
		else
			new_val = cur & ~mask;
	end

	always_comb begin
		frame_d = '0;
		case (cmd_q.func)
			lmfb_pkg::FUNC_PIXEL, lmfb_pkg::FUNC_ROW: begin
				for (int d = 0; d < lmfb_pkg::MAX_DEVICES; d++) begin
					if (2'(d) == chip)
						frame_d.frame_bits[16*d +: 16] = lmfb_pkg::chip_word(row, new_val);
				end
				frame_d.last_frame = 1'b1;
			end
			lmfb_pkg::FUNC_CLEAR: begin
				// cnt walks chip-major, register-minor
				for (int d = 0; d < lmfb_pkg::MAX_DEVICES; d++) begin
					if (2'(d) == cnt_q[4:3])
						frame_d.frame_bits[16*d +: 16] = lmfb_pkg::chip_word(cnt_q[2:0], 8'd0);
				end
				frame_d.last_frame = (cnt_q[4:3] == last_chip) && (cnt_q[2:0] == 3'd7);
			end
			default: begin
				for (int d = 0; d < lmfb_pkg::MAX_DEVICES; d++) begin
					if (3'(d) < n_eff)
						frame_d.frame_bits[16*d +: 16] = lmfb_pkg::chip_word(cnt_q[2:0],
							fb_q[d][cnt_q[2:0]] ^ {8{cmd_q.invert}});
				end
				frame_d.last_frame = cnt_q[2:0] == 3'd7;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			frame_valid_q <= 1'b0;
			for (int d = 0; d < lmfb_pkg::MAX_DEVICES; d++)
				for (int k = 0; k < lmfb_pkg::ROWS; k++)
					fb_q[d][k] <= '0;
		end else begin
			if (emit)
				frame_valid_q <= 1'b1;
			else if (frame_ready)
				frame_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cnt_q   <= '0;
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (emit) begin
						cnt_q <= cnt_q + 5'd1;
						if (frame_d.last_frame)
							state_q <= ST_IDLE;
						if (cmd_q.func inside {lmfb_pkg::FUNC_PIXEL, lmfb_pkg::FUNC_ROW})
							fb_q[chip][row] <= new_val;
						if (cmd_q.func == lmfb_pkg::FUNC_CLEAR) begin
							for (int d = 0; d < lmfb_pkg::MAX_DEVICES; d++)
								for (int k = 0; k < lmfb_pkg::ROWS; k++)
									fb_q[d][k] <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= q_head;
		if (emit)
			frame_q <= frame_d;
	end

	assign status.pop  = pop;
	assign status.busy = state_q == ST_BUSY;
	assign frame_valid = frame_valid_q;
	assign frame       = frame_q;

endmodule

FILE: design/led_matrix_frame_buffer_driver_core.sv
// Top level of the LED matrix frame buffer driver: config register and front/back split.
//
//  channel | direction | handshake             | word
//  cmd     | in        | cmd_valid/cmd_ready   | lmfb_pkg::cmd_t
//  frame   | out       | frame_valid/frame_ready | lmfb_pkg::frame_t
//  apb     | in        | psel/penable, pready=1 | devices_in_use at 0x0
//
// Set-pixel and write-row emit a single frame; clear-all emits one per chip register; refresh one per row.
// The sequencer in the back end emits one frame per cycle unless frame_ready stalls it; a two-word queue
// lets the front end keep taking words meanwhile.
// Reset clears the frame buffer and sets the chip count to 4.
// A stalled frame_ready holds the output word and stops the sequencer only.
`include "led_matrix_frame_buffer_driver_core_assert.svh"

module led_matrix_frame_buffer_driver_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  lmfb_pkg::cmd_t    cmd,
	output logic              frame_valid,
	input  logic              frame_ready,
	output lmfb_pkg::frame_t  frame,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [2:0]              dev_q;
	logic [2:0]              n_eff;
	logic                    cfg_wr;
	logic                    dev_wr;
	logic                    q_avail;
	lmfb_pkg::cmd_t          q_head;
	lmfb_pkg::back_status_t  status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign dev_wr = cfg_wr && paddr[2:2] == lmfb_pkg::REG_DEVICES;
	assign n_eff  = lmfb_pkg::chips_eff(dev_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dev_q <= lmfb_pkg::DEVICES_RESET;
		else if (dev_wr)
			dev_q <= pwdata[2:0];
	end

	always_comb begin
		case (paddr[2:2])
			lmfb_pkg::REG_DEVICES: prdata = {29'd0, dev_q};
			default:               prdata = '0;
		endcase
	end

	lmfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.n_eff     (n_eff),
		.pop       (status.pop),
		.q_avail   (q_avail),
		.q_head    (q_head)
	);

	lmfb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_avail     (q_avail),
		.q_head      (q_head),
		.n_eff       (n_eff),
		.status      (status),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

	`LMFB_ASSERT(a_pop_nonempty, status.pop |-> q_avail, "back end popped an empty queue")
	`LMFB_ASSERT(a_pop_idle, status.pop |-> !status.busy, "pop while a command is in flight")
	`LMFB_ASSERT(a_chips_range, n_eff != 3'd0 && n_eff <= 3'(lmfb_pkg::MAX_DEVICES), "bad chips")
	`LMFB_ASSERT_NEXT(a_cfg_write, dev_wr, dev_q == $past(pwdata[2:0]), "chip count write lost")

endmodule
